// ===== rtl/core/ubx_pkg.sv =====
// ubx frame parser types, constants and message classification
package ubx_pkg;

  localparam logic [7:0] SYNC_CHAR_1    = 8'hB5;
  localparam logic [7:0] SYNC_CHAR_2    = 8'h62;
  localparam logic [7:0] CLS_ACK        = 8'h05;
  localparam logic [7:0] ID_ACK_ACK     = 8'h01;
  localparam logic [7:0] ID_ACK_NAK     = 8'h00;
  localparam logic [7:0] CLS_CFG        = 8'h06;
  localparam logic [7:0] ID_CFG_VALGET  = 8'h8B;
  localparam logic [7:0] CLS_NAV        = 8'h01;
  localparam logic [7:0] ID_NAV_PVT     = 8'h07;
  localparam logic [15:0] MAX_LEN_RESET = 16'd500;
  localparam logic [15:0] ACK_MIN_LEN   = 16'd2;

  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LEN1,
    PH_LEN2,
    PH_PAYLOAD,
    PH_CKA,
    PH_CKB
  } phase_t;

  typedef enum logic [2:0] {
    MT_ACK,
    MT_NAK,
    MT_CFG_VALGET,
    MT_NAV_PVT,
    MT_UNHANDLED
  } msg_type_t;

  typedef enum logic {
    KIND_PAYLOAD,
    KIND_END
  } result_kind_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [7:0]   msg_class;
    logic [7:0]   msg_id;
    logic [15:0]  payload_length;
    logic [15:0]  byte_index;
    logic [7:0]   data_byte;
    logic         checksum_ok;
    msg_type_t    message_type;
    logic         ack_info_valid;
    logic [7:0]   acked_class;
    logic [7:0]   acked_id;
  } result_t;

  function automatic msg_type_t classify(input logic [7:0] cls, input logic [7:0] id);
    msg_type_t mt;
    mt = MT_UNHANDLED;
    if (cls == CLS_ACK && id == ID_ACK_ACK) begin
      mt = MT_ACK;
    end else if (cls == CLS_ACK && id == ID_ACK_NAK) begin
      mt = MT_NAK;
    end else if (cls == CLS_CFG && id == ID_CFG_VALGET) begin
      mt = MT_CFG_VALGET;
    end else if (cls == CLS_NAV && id == ID_NAV_PVT) begin
      mt = MT_NAV_PVT;
    end
    return mt;
  endfunction

endpackage

// ===== rtl/core/ubx_byte_if.sv =====
// received byte channel
interface ubx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/ubx_cfg_if.sv =====
// configuration write channel
interface ubx_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_payload_length;

  modport source (output valid, output max_payload_length, input ready);
  modport sink (input valid, input max_payload_length, output ready);
endinterface

// ===== rtl/core/ubx_result_if.sv =====
// parser result channel
interface ubx_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  msg_class;
  logic [7:0]  msg_id;
  logic [15:0] payload_length;
  logic [15:0] byte_index;
  logic [7:0]  data_byte;
  logic        checksum_ok;
  logic [2:0]  message_type;
  logic        ack_info_valid;
  logic [7:0]  acked_class;
  logic [7:0]  acked_id;

  modport source (
    output valid, output result_kind, output msg_class, output msg_id,
    output payload_length, output byte_index, output data_byte, output checksum_ok,
    output message_type, output ack_info_valid, output acked_class, output acked_id,
    input ready
  );
  modport sink (
    input valid, input result_kind, input msg_class, input msg_id,
    input payload_length, input byte_index, input data_byte, input checksum_ok,
    input message_type, input ack_info_valid, input acked_class, input acked_id,
    output ready
  );
endinterface

// ===== rtl/core/ubx_in_stage.sv =====
// input register for received bytes
module ubx_in_stage (
  input  logic       clk,
  input  logic       rst,
  ubx_byte_if.sink   rx,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  assign rx.ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_data <= rx.rx_byte;
    end
  end

endmodule

// ===== rtl/core/ubx_parse_core.sv =====
// sync hunt, header capture, fletcher sums and result forming
module ubx_parse_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      byte_data,
  input  logic [15:0]     max_len,
  output logic            res_valid,
  output ubx_pkg::result_t res
);
  import ubx_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  frame_class, frame_class_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_received, bytes_received_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  check_a, check_a_next;
  logic [7:0]  first_byte, first_byte_next;
  logic [7:0]  second_byte, second_byte_next;

  logic [7:0]  sum_a_add, sum_b_add;
  logic [15:0] len_full;
  msg_type_t   mt;
  logic        ack_valid;

  assign sum_a_add = sum_a + byte_data;
  assign sum_b_add = sum_b + sum_a_add;
  assign len_full  = {byte_data, frame_length[7:0]};
  assign mt        = classify(frame_class, frame_id);
  assign ack_valid = (mt == MT_ACK || mt == MT_NAK) && (frame_length >= ACK_MIN_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC1;
      frame_class    <= '0;
      frame_id       <= '0;
      frame_length   <= '0;
      bytes_received <= '0;
      sum_a          <= '0;
      sum_b          <= '0;
      check_a        <= '0;
      first_byte     <= '0;
      second_byte    <= '0;
    end else if (step) begin
      phase          <= phase_next;
      frame_class    <= frame_class_next;
      frame_id       <= frame_id_next;
      frame_length   <= frame_length_next;
      bytes_received <= bytes_received_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
      check_a        <= check_a_next;
      first_byte     <= first_byte_next;
      second_byte    <= second_byte_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    frame_class_next    = frame_class;
    frame_id_next       = frame_id;
    frame_length_next   = frame_length;
    bytes_received_next = bytes_received;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    check_a_next        = check_a;
    first_byte_next     = first_byte;
    second_byte_next    = second_byte;
    res_valid           = 1'b0;
    res                 = '0;
    res.msg_class       = frame_class;
    res.msg_id          = frame_id;
    res.payload_length  = frame_length;

    case (phase)
      PH_SYNC2: begin
        phase_next = (byte_data == SYNC_CHAR_2) ? PH_CLASS : PH_SYNC1;
      end
      PH_CLASS: begin
        frame_class_next = byte_data;
        sum_a_next       = byte_data;
        sum_b_next       = byte_data;
        phase_next       = PH_ID;
      end
      PH_ID: begin
        frame_id_next = byte_data;
        sum_a_next    = sum_a_add;
        sum_b_next    = sum_b_add;
        phase_next    = PH_LEN1;
      end
      PH_LEN1: begin
        frame_length_next = {8'h00, byte_data};
        sum_a_next        = sum_a_add;
        sum_b_next        = sum_b_add;
        phase_next        = PH_LEN2;
      end
      PH_LEN2: begin
        if (len_full > max_len) begin
          phase_next          = PH_SYNC1;
          frame_class_next    = '0;
          frame_id_next       = '0;
          frame_length_next   = '0;
          bytes_received_next = '0;
          sum_a_next          = '0;
          sum_b_next          = '0;
        end else begin
          frame_length_next   = len_full;
          sum_a_next          = sum_a_add;
          sum_b_next          = sum_b_add;
          bytes_received_next = '0;
          phase_next          = (len_full != '0) ? PH_PAYLOAD : PH_CKA;
        end
      end
      PH_PAYLOAD: begin
        res_valid       = 1'b1;
        res.result_kind = KIND_PAYLOAD;
        res.byte_index  = bytes_received;
        res.data_byte   = byte_data;
        if (bytes_received == 16'd0) begin
          first_byte_next = byte_data;
        end
        if (bytes_received == 16'd1) begin
          second_byte_next = byte_data;
        end
        bytes_received_next = bytes_received + 16'd1;
        sum_a_next          = sum_a_add;
        sum_b_next          = sum_b_add;
        if (bytes_received_next >= frame_length) begin
          phase_next = PH_CKA;
        end
      end
      PH_CKA: begin
        check_a_next = byte_data;
        phase_next   = PH_CKB;
      end
      PH_CKB: begin
        res_valid           = 1'b1;
        res.result_kind     = KIND_END;
        res.checksum_ok     = (check_a == sum_a) && (byte_data == sum_b);
        res.message_type    = mt;
        res.ack_info_valid  = ack_valid;
        res.acked_class     = ack_valid ? first_byte : 8'h00;
        res.acked_id        = ack_valid ? second_byte : 8'h00;
        phase_next          = PH_SYNC1;
        frame_class_next    = '0;
        frame_id_next       = '0;
        frame_length_next   = '0;
        bytes_received_next = '0;
        sum_a_next          = '0;
        sum_b_next          = '0;
      end
      default: begin
        phase_next = (byte_data == SYNC_CHAR_1) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

endmodule

// ===== rtl/core/ubx_out_stage.sv =====
// result register toward the result channel
module ubx_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ubx_pkg::result_t res_in,
  output logic             free,
  ubx_result_if.source     res
);
  import ubx_pkg::*;

  result_t held;
  logic    held_valid;

  assign free = !held_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (res.ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res_in;
    end
  end

  assign res.valid          = held_valid;
  assign res.result_kind    = held.result_kind;
  assign res.msg_class      = held.msg_class;
  assign res.msg_id         = held.msg_id;
  assign res.payload_length = held.payload_length;
  assign res.byte_index     = held.byte_index;
  assign res.data_byte      = held.data_byte;
  assign res.checksum_ok    = held.checksum_ok;
  assign res.message_type   = held.message_type;
  assign res.ack_info_valid = held.ack_info_valid;
  assign res.acked_class    = held.acked_class;
  assign res.acked_id       = held.acked_id;

endmodule

// ===== rtl/core/ubx_frame_parser.sv =====
// ubx frame parser top level
//
//   channel  dir  payload                       handshake
//   rx       in   rx_byte                       valid / ready
//   cfg      in   max_payload_length            valid / ready, always ready
//   res      out  payload byte or end of frame  valid / ready
//
// one byte per cycle unless res stalls; each result is registered when parsed
// bytes pass an input register, the parse logic and a result register
// a stalled result holds the parse step; one more byte waits in the input register
// reset clears the parser to sync hunting and the length limit to 500
module ubx_frame_parser (
  input logic          clk,
  input logic          rst,
  ubx_byte_if.sink     rx,
  ubx_cfg_if.sink      cfg,
  ubx_result_if.source res
);
  import ubx_pkg::*;

  logic [15:0] max_len;
  logic        byte_valid;
  logic [7:0]  byte_data;
  logic        out_free;
  logic        step;
  logic        core_valid;
  result_t     core_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg.valid) begin
      max_len <= cfg.max_payload_length;
    end
  end

  assign step = byte_valid && out_free;

  ubx_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .advance    (step),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  ubx_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_data (byte_data),
    .max_len   (max_len),
    .res_valid (core_valid),
    .res       (core_res)
  );

  ubx_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step && core_valid),
    .res_in (core_res),
    .free   (out_free),
    .res    (res)
  );

endmodule
